// ----- src/olad_pkg.sv -----
package olad_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int COUNT_OUT_W  = 5;

   // request kinds
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_APPENDED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic wr;   // load the request value
      logic sh;   // take the neighbor's entry
      logic cmp;  // compare against the request value
   } cell_ctl_type;

endpackage

// ----- src/ordered_list_append_delete.sv -----
// result: append, clear and delete on an empty list register their result in the cycle
// after the request; a delete scans one cell per cycle over the chain of cells after a
// parallel compare, until a match or the last occupied cell.
// throughput: one request at a time; a new request is taken once the result
// register is free or being drained.
// reset: synchronous, active high; clears the entry count and control, not the cells.
module ordered_list_append_delete
   import olad_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] entry_count, rest zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [VALUE_W-1:0]     key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]     rsp_removed_ff, rsp_removed_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   full;
   logic                   scan_hit;
   logic                   scan_last;
   logic [31:0]            occ_in_ext;
   logic [CAPACITY-1:0]    match_vec;
   logic [VALUE_W-1:0]     entry_vec [CAPACITY];
   cell_ctl_type           ctl_vec [CAPACITY];

   assign req_tready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign full       = (32'(occ_ff) >= 32'(CAPACITY));
   assign scan_hit   = (state_ff == STATE_SCAN) && match_vec[idx_ff];
   assign scan_last  = (32'(idx_ff) + 32'd1 >= 32'(occ_ff));

   // cell row: entries shift one place toward the head behind the hit
   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [VALUE_W-1:0] nxt;
      assign ctl_vec[j].wr  = accept && (req_tuser == KIND_APPEND) && !full
                              && (32'(occ_ff) == 32'(j));
      assign ctl_vec[j].sh  = scan_hit && (32'(idx_ff) <= 32'(j));
      assign ctl_vec[j].cmp = accept && (req_tuser == KIND_DELETE);
      if (j == CAPACITY - 1) begin : g_tail
         assign nxt = entry_vec[j];
      end else begin : g_link
         assign nxt = entry_vec[j+1];
      end
      olad_cell u_cell (
         .clock      (clock),
         .ctl        (ctl_vec[j]),
         .item_value (req_tdata),
         .next_entry (nxt),
         .entry      (entry_vec[j]),
         .match      (match_vec[j])
      );
   end

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      idx_in         = idx_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  KIND_APPEND: begin
                     rsp_valid_in   = 1'b1;
                     rsp_removed_in = '0;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_APPENDED;
                        occ_in        = occ_ff + CNT_W'(1);
                     end
                  end
                  KIND_DELETE: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STAT_EMPTY;
                        rsp_removed_in = '0;
                     end else begin
                        key_in   = req_tdata;
                        idx_in   = '0;
                        state_in = STATE_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STAT_EMPTY;
                     rsp_removed_in = '0;
                     occ_in         = '0;
                  end
                  default: ;
               endcase
            end
         end
         STATE_SCAN: begin
            if (scan_hit) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_DELETED;
               rsp_removed_in = key_ff;
               occ_in         = occ_ff - CNT_W'(1);
               state_in       = STATE_IDLE;
            end else if (scan_last) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_NOT_FOUND;
               rsp_removed_in = '0;
               state_in       = STATE_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: state_in = STATE_IDLE;
      endcase
      occ_in_ext   = 32'(occ_in);
      rsp_count_in = occ_in_ext[COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      if (rsp_valid_in) begin
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_removed_ff};

endmodule

// ----- src/olad_cell.sv -----
module olad_cell
   import olad_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] item_value,
   input  logic [VALUE_W-1:0] next_entry,
   output logic [VALUE_W-1:0] entry,
   output logic               match
);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr) begin
         entry_in = item_value;
      end else if (ctl.sh) begin
         entry_in = next_entry;
      end
      match_in = ctl.cmp ? (entry_ff == item_value) : match_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ----- src/olad_checker.sv -----
module olad_checker
   import olad_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // removed value only on a successful delete
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_DELETED) |-> rsp_tdata[31:0] == 32'd0)
      else $error("removed value set without a delete");

   // an empty status always reports no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_EMPTY) |-> rsp_tdata[36:32] == 5'd0)
      else $error("empty list with nonzero count");

   // no new request is taken while a result waits on a stalled output
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request taken while result stalled");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- test/tb_ordered_list_append_delete.sv -----
`timescale 1ns / 100ps

module tb_ordered_list_append_delete;
   import olad_pkg::*;

   localparam int          LIST_DEPTH   = CAPACITY_DEF;
   localparam int          TARGET_REQS  = 1450;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          SETTLE_CYC   = 2 * LIST_DEPTH + 8;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] value;
      bit          drain;   // hold off until every response is back
   } list_req_type;

   typedef struct {
      logic [STATUS_W-1:0]    status;
      logic [31:0]            removed;
      logic [COUNT_OUT_W-1:0] count;
   } list_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   list_req_type pending_reqs[$];
   list_rsp_type awaited_rsps[$];
   logic [31:0]  held_values[$];   // predicted list contents, head first

   int  error_count = 0;
   int  rsp_count = 0;
   int  status_seen[5] = '{default: 0};
   int  peak_count = 0;
   int  cycle_count = 0;
   logic calm = 1'b0;             // no idling while set

   ordered_list_append_delete uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // list behavior: append at tail, delete first match, clear; other kinds get no response
   function automatic void predict_list_op(logic [1:0] kind, logic [31:0] value);
      list_rsp_type r;
      int hit;
      r.status = STAT_EMPTY;
      r.removed = '0;
      hit = -1;
      case (kind)
         KIND_APPEND: begin
            if (held_values.size() >= LIST_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               held_values.push_back(value);
               r.status = STAT_APPENDED;
            end
         end
         KIND_DELETE: begin
            if (held_values.size() == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               foreach (held_values[i])
                  if (hit < 0 && held_values[i] == value) hit = i;
               if (hit < 0) begin
                  r.status = STAT_NOT_FOUND;
               end else begin
                  r.removed = held_values[hit];
                  held_values.delete(hit);
                  r.status = STAT_DELETED;
               end
            end
         end
         KIND_CLEAR: begin
            held_values.delete();
            r.status = STAT_EMPTY;
         end
         default: return;
      endcase
      r.count = COUNT_OUT_W'(held_values.size());
      if (held_values.size() > peak_count) peak_count = held_values.size();
      awaited_rsps.push_back(r);
   endfunction

   task automatic queue_req(logic [1:0] kind, logic [31:0] value, bit drain = 1'b0);
      list_req_type item;
      item.kind = kind;
      item.value = value;
      item.drain = drain;
      pending_reqs.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin
      int gap_left;
      list_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) predict_list_op(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && awaited_rsps.size() > 0)) begin
               item = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= item.value;
               req_tuser <= item.kind;
               gap_left = idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      int stall_left;
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (awaited_rsps.size() == 0) begin
               $error("response with no request outstanding: status %0d count %0d",
                      rsp_tuser, rsp_tdata[36:32]);
               error_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[31:0] !== want.removed) begin
                  $error("removed_value: expected %0d, actual %0d",
                         $signed(want.removed), $signed(rsp_tdata[31:0]));
                  error_count++;
               end
               if (rsp_tdata[36:32] !== want.count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.count, rsp_tdata[36:32]);
                  error_count++;
               end
               if (want.status <= STAT_FULL) status_seen[want.status]++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_rsps.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [31:0] pool[6];
      int queued;
      int phase_len;
      int mode;
      int r;
      logic [31:0] v;

      // directed: extremes, duplicates, head/tail removal, empty and ignored cases
      queue_req(KIND_CLEAR, 32'h0);
      queue_req(KIND_DELETE, 32'h8000_0000);
      queue_req(KIND_APPEND, 32'h8000_0000);
      queue_req(KIND_APPEND, 32'h7fff_ffff);
      queue_req(KIND_APPEND, 32'hffff_ffff);
      queue_req(KIND_APPEND, 32'h0000_0000);
      queue_req(KIND_APPEND, 32'hffff_ffff);
      queue_req(KIND_DELETE, 32'h0001_2345);
      queue_req(KIND_DELETE, 32'hffff_ffff);
      queue_req(KIND_DELETE, 32'h8000_0000);
      queue_req(KIND_UNUSED, 32'hdead_beef);
      queue_req(KIND_DELETE, 32'hffff_ffff);
      queue_req(KIND_DELETE, 32'h7fff_ffff);
      queue_req(KIND_DELETE, 32'h0000_0000);
      queue_req(KIND_DELETE, 32'h0000_0000);
      queue_req(KIND_APPEND, 32'h5a5a_a5a5);
      queue_req(KIND_CLEAR, 32'hffff_ffff, 1'b1);
      queue_req(KIND_DELETE, 32'h5a5a_a5a5);
      queued = 17;

      // random phases: append-heavy to reach full, delete-heavy to drain, or balanced;
      // values mostly from a small pool so deletes find matches
      mode = 0;
      while (queued < TARGET_REQS) begin
         foreach (pool[i]) begin
            r = $urandom_range(0, 9);
            case (r)
               0: pool[i] = 32'h8000_0000;
               1: pool[i] = 32'h7fff_ffff;
               2: pool[i] = 32'h0;
               3: pool[i] = 32'hffff_ffff;
               default: pool[i] = $urandom;
            endcase
         end
         phase_len = $urandom_range(20, 60);
         for (int n = 0; n < phase_len; n++) begin
            r = $urandom_range(0, 99);
            v = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 5)];
            if (r < 2) begin
               queue_req(KIND_UNUSED, $urandom);
               continue;
            end
            if (r < 5)
               queue_req(KIND_CLEAR, v);
            else if (r < (mode == 0 ? 80 : mode == 1 ? 30 : 52))
               queue_req(KIND_APPEND, v);
            else
               queue_req(KIND_DELETE, v);
            queued++;
         end
         if ($urandom_range(0, 9) == 0) pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
         mode = $urandom_range(0, 2);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (awaited_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("%0d responses checked: %0d appended, %0d deleted, %0d not found,",
               rsp_count, status_seen[STAT_APPENDED], status_seen[STAT_DELETED],
               status_seen[STAT_NOT_FOUND]);
      $display("%0d empty or cleared, %0d rejected as full; list peaked at %0d entries",
               status_seen[STAT_EMPTY], status_seen[STAT_FULL], peak_count);
      if (error_count == 0 && awaited_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/olad_pkg.sv
src/olad_cell.sv
src/ordered_list_append_delete.sv
src/olad_checker.sv
test/tb_ordered_list_append_delete.sv
